@@ rtl/adsr_envelope_generator_assert.svh @@
// Assertion helpers for the ADSR envelope block.
// Both expect clk and rst in the enclosing module.
`ifndef ADSR_ENVELOPE_GENERATOR_ASSERT_SVH
`define ADSR_ENVELOPE_GENERATOR_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define ADSR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Trigger this cycle implies consequence on the next one.
`define ADSR_ASSERT_NEXT(label, trig, cons, msg) \
  `ADSR_ASSERT(label, (trig) |=> (cons), msg)

`endif

@@ rtl/adsr_pkg.sv @@
package adsr_pkg;

  // Default for the top-level count width parameter
  localparam int COUNT_BITS_DEF = 24;

  // Field and register widths
  localparam int LEVEL_W    = 17;
  localparam int LEN_W      = 24;
  localparam int COEF_W     = 16;
  localparam int FRAC_W     = 16;
  localparam int QUO_W      = 16;
  localparam int PHASE_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Q16 full scale and snap window in LSB
  localparam logic [LEVEL_W-1:0] FULL_SCALE = 17'h10000;
  localparam int SNAP_MARGIN = 7;

  // Register reset values
  localparam logic                  CURVE_MODE_RST     = 1'b0;
  localparam logic [LEVEL_W-1:0]    SUSTAIN_LEVEL_RST  = 17'd49152;
  localparam logic [LEN_W-1:0]      ATTACK_LENGTH_RST  = 24'd480;
  localparam logic [LEN_W-1:0]      DECAY_LENGTH_RST   = 24'd4800;
  localparam logic [LEN_W-1:0]      RELEASE_LENGTH_RST = 24'd4800;
  localparam logic [COEF_W-1:0]     ATTACK_COEF_RST    = 16'd1256;
  localparam logic [COEF_W-1:0]     DECAY_COEF_RST     = 16'd126;
  localparam logic [COEF_W-1:0]     RELEASE_COEF_RST   = 16'd126;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE    = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_DECAY   = 3'd2,
    PH_SUSTAIN = 3'd3,
    PH_RELEASE = 3'd4
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CURVE_MODE     = 3'd0,
    REG_SUSTAIN_LEVEL  = 3'd1,
    REG_ATTACK_LENGTH  = 3'd2,
    REG_DECAY_LENGTH   = 3'd3,
    REG_RELEASE_LENGTH = 3'd4,
    REG_ATTACK_COEF    = 3'd5,
    REG_DECAY_COEF     = 3'd6,
    REG_RELEASE_COEF   = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_MUL,
    SEQ_DIV,
    SEQ_DONE
  } seq_t;

  typedef struct packed {
    logic                curve_mode;
    logic [LEVEL_W-1:0]  sustain_level;
    logic [LEN_W-1:0]    attack_length;
    logic [LEN_W-1:0]    decay_length;
    logic [LEN_W-1:0]    release_length;
    logic [COEF_W-1:0]   attack_coef;
    logic [COEF_W-1:0]   decay_coef;
    logic [COEF_W-1:0]   release_coef;
  } cfg_t;

  typedef struct packed {
    logic gate_level;
  } in_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] envelope_level;
    logic [PHASE_W-1:0] phase_now;
  } out_item_t;

endpackage

@@ rtl/adsr_stream_if.sv @@
interface adsr_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/adsr_cfg_regs.sv @@
module adsr_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [adsr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [adsr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output adsr_pkg::cfg_t                    cfg
);
  import adsr_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.curve_mode     <= CURVE_MODE_RST;
      cfg.sustain_level  <= SUSTAIN_LEVEL_RST;
      cfg.attack_length  <= ATTACK_LENGTH_RST;
      cfg.decay_length   <= DECAY_LENGTH_RST;
      cfg.release_length <= RELEASE_LENGTH_RST;
      cfg.attack_coef    <= ATTACK_COEF_RST;
      cfg.decay_coef     <= DECAY_COEF_RST;
      cfg.release_coef   <= RELEASE_COEF_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CURVE_MODE:     cfg.curve_mode     <= cfg_wdata[0];
        REG_SUSTAIN_LEVEL:  cfg.sustain_level  <= cfg_wdata[LEVEL_W-1:0];
        REG_ATTACK_LENGTH:  cfg.attack_length  <= cfg_wdata[LEN_W-1:0];
        REG_DECAY_LENGTH:   cfg.decay_length   <= cfg_wdata[LEN_W-1:0];
        REG_RELEASE_LENGTH: cfg.release_length <= cfg_wdata[LEN_W-1:0];
        REG_ATTACK_COEF:    cfg.attack_coef    <= cfg_wdata[COEF_W-1:0];
        REG_DECAY_COEF:     cfg.decay_coef     <= cfg_wdata[COEF_W-1:0];
        REG_RELEASE_COEF:   cfg.release_coef   <= cfg_wdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/adsr_mul.sv @@
// Radix-4 shift-add multiplier, multiplier digits taken LSB first.
module adsr_mul #(
  parameter int MCAND_W = adsr_pkg::LEVEL_W,
  parameter int MPLR_W  = adsr_pkg::LEN_W
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [MCAND_W-1:0]          mcand,
  input  logic [MPLR_W-1:0]           mplr,
  output logic                        busy,
  output logic [MCAND_W+MPLR_W-1:0]   product
);
  import adsr_pkg::*;

  localparam int PROD_W = MCAND_W + MPLR_W;
  localparam int STEPS  = MPLR_W / 2;
  localparam int CNT_W  = $clog2(STEPS + 1);
  localparam int PART_W = MCAND_W + 2;

  logic [PROD_W-1:0] acc;
  logic [PART_W-1:0] mcand1;
  logic [PART_W-1:0] mcand3;
  logic [CNT_W-1:0]  steps_left;
  logic [PART_W-1:0] part;
  logic [PART_W-1:0] hi_sum;

  always_comb begin
    case (acc[1:0])
      2'd0:    part = '0;
      2'd1:    part = mcand1;
      2'd2:    part = {mcand1[PART_W-2:0], 1'b0};
      default: part = mcand3;
    endcase
  end

  assign hi_sum  = PART_W'(acc[PROD_W-1 -: MCAND_W]) + part;
  assign busy    = (steps_left != '0);
  assign product = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      steps_left <= '0;
    end else if (start) begin
      steps_left <= CNT_W'(STEPS);
    end else if (busy) begin
      steps_left <= steps_left - 1'b1;
    end
  end

  // upper part accumulates, lower part shifts out consumed digits
  always_ff @(posedge clk) begin
    if (start) begin
      acc    <= {{MCAND_W{1'b0}}, mplr};
      mcand1 <= PART_W'(mcand);
      mcand3 <= PART_W'({mcand, 1'b0}) + PART_W'(mcand);
    end else if (busy) begin
      acc    <= {hi_sum, acc[MPLR_W-1:2]};
    end
  end

endmodule

@@ rtl/adsr_div.sv @@
`include "adsr_envelope_generator_assert.svh"

// Restoring divider, one quotient bit per cycle. The upper numerator
// bits must already be below the divisor.
module adsr_div #(
  parameter int NUM_W = adsr_pkg::LEVEL_W + adsr_pkg::LEN_W,
  parameter int DEN_W = adsr_pkg::LEN_W,
  parameter int QUO_W = adsr_pkg::QUO_W
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [NUM_W-1:0]   numer,
  input  logic [DEN_W-1:0]   denom,
  output logic               busy,
  output logic [QUO_W-1:0]   quotient
);
  import adsr_pkg::*;

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [DEN_W-1:0] rem;
  logic [QUO_W-1:0] lo;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] steps_left;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  assign trial    = {rem, lo[QUO_W-1]};
  assign fits     = (trial >= {1'b0, den_q});
  assign diff     = trial - {1'b0, den_q};
  assign busy     = (steps_left != '0);
  assign quotient = lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      steps_left <= '0;
    end else if (start) begin
      steps_left <= CNT_W'(QUO_W);
    end else if (busy) begin
      steps_left <= steps_left - 1'b1;
    end
  end

  // lo holds the unconsumed numerator bits, then fills with quotient bits
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= DEN_W'(numer[NUM_W-1:QUO_W]);
      lo    <= numer[QUO_W-1:0];
      den_q <= denom;
    end else if (busy) begin
      rem   <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      lo    <= {lo[QUO_W-2:0], fits};
    end
  end

  `ADSR_ASSERT(a_div_rem_bound, busy |-> (rem < den_q), "divider remainder not below divisor")

endmodule

@@ rtl/adsr_envelope_generator.sv @@
// ADSR envelope generator: one Q16 envelope level per gate sample.
// Each accepted sample is multiplied, then divided while a linear attack, decay or
//   release is still ramping, and the result is registered into the output stream.
// One sample at a time: no new sample is taken until its result is in the output register;
//   the multiplier scans max(COUNT_BITS,17) bits, 2 per cycle, the divider a 16-bit quotient.
// Reset: synchronous active-high rst; phase idle, count, level, gate history zero.
`include "adsr_envelope_generator_assert.svh"

module adsr_envelope_generator #(
  parameter int COUNT_BITS = adsr_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  adsr_stream_if.sink                       samples,
  adsr_stream_if.source                     envelope,
  input  logic                              cfg_wr_en,
  input  logic [adsr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [adsr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import adsr_pkg::*;

  // Multiplier scans the wider of the count and a Q16 level, even digit count
  localparam int MPLR_W = ((COUNT_BITS > LEVEL_W ? COUNT_BITS : LEVEL_W) + 1) / 2 * 2;
  localparam int PROD_W = LEVEL_W + MPLR_W;
  localparam int CMP_W  = (COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W;

  localparam logic [LEVEL_W-1:0] ATK_SNAP = LEVEL_W'(FULL_SCALE - LEVEL_W'(SNAP_MARGIN));
  localparam logic [LEVEL_W-1:0] REL_SNAP = LEVEL_W'(SNAP_MARGIN);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  cfg_t cfg;

  adsr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // sustain above full scale behaves as full scale
  logic [LEVEL_W-1:0] sus;
  assign sus = (cfg.sustain_level > FULL_SCALE) ? FULL_SCALE : cfg.sustain_level;

  // ---------------------------------------------------------------------------
  // Envelope state
  // ---------------------------------------------------------------------------
  seq_t                  seq, seq_next;
  phase_t                phase;
  logic [COUNT_BITS-1:0] sample_count;
  logic [LEVEL_W-1:0]    level;
  logic                  last_gate;

  logic accept;
  logic out_free;
  logic mul_start, mul_busy;
  logic div_start, div_busy;
  logic finish;

  assign accept   = samples.valid && samples.ready;
  assign out_free = !envelope.valid || envelope.ready;

  // ---------------------------------------------------------------------------
  // Gate edge handling, applied on the input transfer
  // ---------------------------------------------------------------------------
  logic                  gate, rise, fall;
  phase_t                ph_entry;
  logic [COUNT_BITS-1:0] cnt_entry;
  logic [LEVEL_W-1:0]    lvl_entry;

  assign gate      = samples.data.gate_level;
  assign rise      = gate && !last_gate;
  assign fall      = !gate && last_gate;
  assign ph_entry  = rise ? PH_ATTACK : (fall ? PH_RELEASE : phase);
  // first sample of a new phase sees zero elapsed time
  assign cnt_entry = (rise || fall) ? '0 : sample_count;
  // exponential attack restarts from zero
  assign lvl_entry = (rise && cfg.curve_mode) ? '0 : level;

  // ---------------------------------------------------------------------------
  // Multiplier operands
  //   linear:      ramp span * elapsed count, later divided by the length
  //   exponential: distance to target * step fraction, then >> 16
  // ---------------------------------------------------------------------------
  logic [LEVEL_W-1:0] mcand;
  logic [MPLR_W-1:0]  mplr;
  logic [PROD_W-1:0]  product;

  always_comb begin
    mcand = '0;
    mplr  = '0;
    if (!cfg.curve_mode) begin
      mplr = MPLR_W'(cnt_entry);
      case (ph_entry)
        PH_ATTACK:  mcand = FULL_SCALE;
        PH_DECAY:   mcand = FULL_SCALE - sus;
        PH_RELEASE: mcand = sus;
        default:    mcand = '0;
      endcase
    end else begin
      case (ph_entry)
        PH_ATTACK: begin
          mcand = (lvl_entry < FULL_SCALE) ? FULL_SCALE - lvl_entry : '0;
          mplr  = MPLR_W'(cfg.attack_coef);
        end
        PH_DECAY: begin
          mcand = (lvl_entry > sus) ? lvl_entry - sus : sus - lvl_entry;
          mplr  = MPLR_W'(cfg.decay_coef);
        end
        PH_RELEASE: begin
          mcand = lvl_entry;
          mplr  = MPLR_W'(FULL_SCALE - {1'b0, cfg.release_coef});
        end
        default: begin
          mcand = '0;
          mplr  = '0;
        end
      endcase
    end
  end

  adsr_mul #(
    .MCAND_W (LEVEL_W),
    .MPLR_W  (MPLR_W)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (mcand),
    .mplr    (mplr),
    .busy    (mul_busy),
    .product (product)
  );

  // ---------------------------------------------------------------------------
  // Linear phase end test and divider
  // ---------------------------------------------------------------------------
  logic [LEN_W-1:0] sel_len;
  logic             lin_done;
  logic             need_div;
  logic [QUO_W-1:0] quo;

  always_comb begin
    case (phase)
      PH_ATTACK: sel_len = cfg.attack_length;
      PH_DECAY:  sel_len = cfg.decay_length;
      default:   sel_len = cfg.release_length;
    endcase
  end

  // a saturated counter ends the phase just like reaching the length
  assign lin_done = (CMP_W'(sample_count) >= CMP_W'(sel_len)) || (&sample_count);
  assign need_div = !cfg.curve_mode && !lin_done &&
                    (phase == PH_ATTACK || phase == PH_DECAY || phase == PH_RELEASE);

  adsr_div #(
    .NUM_W (PROD_W),
    .DEN_W (LEN_W),
    .QUO_W (QUO_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .numer    (product),
    .denom    (sel_len),
    .busy     (div_busy),
    .quotient (quo)
  );

  // ---------------------------------------------------------------------------
  // End-of-sample update
  // ---------------------------------------------------------------------------
  logic [LEVEL_W-1:0]    q17;
  logic [LEVEL_W-1:0]    step;
  logic [LEVEL_W-1:0]    atk_sum;
  logic [LEVEL_W-1:0]    dec_lvl;
  logic [COUNT_BITS-1:0] cnt_inc;
  phase_t                fin_phase;
  logic [COUNT_BITS-1:0] fin_count;
  logic [LEVEL_W-1:0]    fin_level;
  logic [LEVEL_W-1:0]    fin_env;

  assign q17     = LEVEL_W'(quo);
  assign step    = product[FRAC_W +: LEVEL_W];
  assign atk_sum = level + step;
  assign dec_lvl = (level > sus) ? level - step : level + step;
  assign cnt_inc = (&sample_count) ? sample_count : sample_count + 1'b1;

  always_comb begin
    fin_phase = phase;
    fin_count = sample_count;
    fin_level = level;
    fin_env   = '0;
    if (!cfg.curve_mode) begin
      case (phase)
        PH_ATTACK: begin
          if (lin_done) begin
            fin_phase = PH_DECAY;
            fin_count = COUNT_BITS'(1);
            fin_env   = FULL_SCALE;
          end else begin
            fin_count = cnt_inc;
            fin_env   = q17;
          end
        end
        PH_DECAY: begin
          if (lin_done) begin
            fin_phase = PH_SUSTAIN;
            fin_count = COUNT_BITS'(1);
            fin_env   = sus;
          end else begin
            fin_count = cnt_inc;
            fin_env   = FULL_SCALE - q17;
          end
        end
        PH_SUSTAIN: fin_env = sus;
        PH_RELEASE: begin
          fin_count = cnt_inc;
          if (lin_done) begin
            fin_phase = PH_IDLE;
            fin_env   = '0;
          end else begin
            fin_env   = sus - q17;
          end
        end
        default: begin
          fin_phase = PH_IDLE;
          fin_env   = '0;
        end
      endcase
    end else begin
      case (phase)
        PH_ATTACK: begin
          if (atk_sum >= ATK_SNAP) begin
            fin_phase = PH_DECAY;
            fin_count = COUNT_BITS'(1);
            fin_level = FULL_SCALE;
          end else begin
            fin_count = cnt_inc;
            fin_level = atk_sum;
          end
          fin_env = fin_level;
        end
        PH_DECAY: begin
          // also snaps when the level sits below sustain
          if ({1'b0, dec_lvl} <= {1'b0, sus} + (LEVEL_W + 1)'(SNAP_MARGIN)) begin
            fin_phase = PH_SUSTAIN;
            fin_count = COUNT_BITS'(1);
            fin_level = sus;
          end else begin
            fin_count = cnt_inc;
            fin_level = dec_lvl;
          end
          fin_env = fin_level;
        end
        PH_SUSTAIN: begin
          fin_count = cnt_inc;
          fin_env   = level;
        end
        PH_RELEASE: begin
          fin_count = cnt_inc;
          if (step <= REL_SNAP) begin
            fin_phase = PH_IDLE;
            fin_level = '0;
          end else begin
            fin_level = step;
          end
          fin_env = fin_level;
        end
        default: begin
          fin_phase = PH_IDLE;
          fin_env   = '0;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: idle -> multiply -> (divide) -> done, one sample at a time
  // ---------------------------------------------------------------------------
  always_comb begin
    seq_next = seq;
    unique case (seq)
      SEQ_IDLE: if (samples.valid) seq_next = SEQ_MUL;
      SEQ_MUL:  if (!mul_busy) seq_next = need_div ? SEQ_DIV : SEQ_DONE;
      SEQ_DIV:  if (!div_busy) seq_next = SEQ_DONE;
      SEQ_DONE: if (out_free) seq_next = SEQ_IDLE;
      default:  seq_next = SEQ_IDLE;
    endcase
  end

  always_comb begin
    samples.ready = (seq == SEQ_IDLE);
    mul_start     = (seq == SEQ_IDLE) && samples.valid;
    div_start     = (seq == SEQ_MUL) && !mul_busy && need_div;
    // result goes out as soon as the output register is free
    finish        = (seq == SEQ_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq            <= SEQ_IDLE;
      phase          <= PH_IDLE;
      sample_count   <= '0;
      level          <= '0;
      last_gate      <= 1'b0;
      envelope.valid <= 1'b0;
    end else begin
      seq <= seq_next;
      if (accept) begin
        last_gate    <= gate;
        phase        <= ph_entry;
        sample_count <= cnt_entry;
        level        <= lvl_entry;
      end else if (finish) begin
        phase        <= fin_phase;
        sample_count <= fin_count;
        level        <= fin_level;
      end
      if (finish) begin
        envelope.valid <= 1'b1;
      end else if (envelope.ready) begin
        envelope.valid <= 1'b0;
      end
    end
  end

  // output register: holds while the consumer stalls
  always_ff @(posedge clk) begin
    if (finish) begin
      envelope.data <= out_item_t'{envelope_level: fin_env,
                                   phase_now:      PHASE_W'(fin_phase)};
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `ADSR_ASSERT_NEXT(a_accept_starts_mul, accept, (seq == SEQ_MUL) && mul_busy, "no multiply after transfer")
  `ADSR_ASSERT(a_out_from_done, $rose(envelope.valid) |-> $past(seq == SEQ_DONE), "output loaded outside done")
  `ADSR_ASSERT(a_div_after_mul, (seq == SEQ_DIV) |-> !mul_busy, "divider running with multiplier busy")

endmodule

@@ dv/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import adsr_pkg::*;

  // Longest quiet time between transfers before the run is declared hung.
  // Slowest correct case: linear latency, the largest source gap and sink stall,
  // plus the one long output hold-off below.
  localparam int unsigned STUCK_LIMIT  = 4000;
  // Settle time after the last result, above the linear-mode latency.
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned HOLD_OFF     = 400;

  localparam longint unsigned Q16_ONE   = 65536;
  localparam longint unsigned COUNT_TOP = (64'd1 << COUNT_BITS_DEF) - 1;

  logic clk = 1'b0;
  logic rst;

  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  adsr_stream_if #(.payload_t(in_item_t))  samples ();
  adsr_stream_if #(.payload_t(out_item_t)) envelope ();

  adsr_envelope_generator dut (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples),
    .envelope  (envelope),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Envelope predictor: own copy of the register file and the generator state.
  // ---------------------------------------------------------------------------
  cfg_t            shadow_cfg;
  phase_t          env_phase;
  longint unsigned ramp_count;   // samples elapsed in the current phase
  longint unsigned env_level;    // exponential mode level, Q16
  logic            gate_prev;
  int unsigned     phase_seen [5];

  function automatic void apply_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_CURVE_MODE:     shadow_cfg.curve_mode     = val[0];
      REG_SUSTAIN_LEVEL:  shadow_cfg.sustain_level  = val[LEVEL_W-1:0];
      REG_ATTACK_LENGTH:  shadow_cfg.attack_length  = val[LEN_W-1:0];
      REG_DECAY_LENGTH:   shadow_cfg.decay_length   = val[LEN_W-1:0];
      REG_RELEASE_LENGTH: shadow_cfg.release_length = val[LEN_W-1:0];
      REG_ATTACK_COEF:    shadow_cfg.attack_coef    = val[COEF_W-1:0];
      REG_DECAY_COEF:     shadow_cfg.decay_coef     = val[COEF_W-1:0];
      REG_RELEASE_COEF:   shadow_cfg.release_coef   = val[COEF_W-1:0];
      default: ;
    endcase
  endfunction

  // A linear phase ends at its length or when the counter saturates.
  function automatic bit ramp_done(longint unsigned len);
    return ramp_count >= len || ramp_count >= COUNT_TOP;
  endfunction

  function automatic out_item_t envelope_step(logic gate);
    longint unsigned sus;
    longint unsigned lvl;
    longint unsigned span;
    bit              advance;
    out_item_t       res;
    // sustain above full scale is clamped
    sus = (shadow_cfg.sustain_level > FULL_SCALE) ? Q16_ONE : shadow_cfg.sustain_level;

    // gate edges restart the count; a rising edge also clears the exp level
    if (gate && !gate_prev) begin
      env_phase  = PH_ATTACK;
      ramp_count = 0;
      if (shadow_cfg.curve_mode)
        env_level = 0;
    end else if (!gate && gate_prev) begin
      env_phase  = PH_RELEASE;
      ramp_count = 0;
    end
    gate_prev = gate;

    advance = 1'b1;
    lvl     = 0;
    if (!shadow_cfg.curve_mode) begin
      // linear ramps; a zero length ends the phase without dividing
      case (env_phase)
        PH_ATTACK: begin
          if (ramp_done(shadow_cfg.attack_length)) begin
            env_phase  = PH_DECAY;
            ramp_count = 0;
            lvl        = Q16_ONE;
          end else begin
            lvl = (Q16_ONE * ramp_count) / shadow_cfg.attack_length;
          end
        end
        PH_DECAY: begin
          if (ramp_done(shadow_cfg.decay_length)) begin
            env_phase  = PH_SUSTAIN;
            ramp_count = 0;
            lvl        = sus;
          end else begin
            lvl = Q16_ONE - ((Q16_ONE - sus) * ramp_count) / shadow_cfg.decay_length;
          end
        end
        PH_SUSTAIN: begin
          lvl     = sus;
          advance = 1'b0;
        end
        PH_RELEASE: begin
          if (ramp_done(shadow_cfg.release_length)) begin
            env_phase = PH_IDLE;
            lvl       = 0;
          end else begin
            lvl = sus - (sus * ramp_count) / shadow_cfg.release_length;
          end
        end
        default: begin
          env_phase = PH_IDLE;
          advance   = 1'b0;
        end
      endcase
    end else begin
      // exponential approach, truncating each step, snapping near the target
      case (env_phase)
        PH_ATTACK: begin
          span      = (env_level < Q16_ONE) ? Q16_ONE - env_level : 0;
          env_level = env_level + ((span * shadow_cfg.attack_coef) >> 16);
          if (env_level >= Q16_ONE - SNAP_MARGIN) begin
            env_phase  = PH_DECAY;
            ramp_count = 0;
            env_level  = Q16_ONE;
          end
        end
        PH_DECAY: begin
          if (env_level > sus)
            env_level = env_level - (((env_level - sus) * shadow_cfg.decay_coef) >> 16);
          else
            env_level = env_level + (((sus - env_level) * shadow_cfg.decay_coef) >> 16);
          if (env_level <= sus + SNAP_MARGIN) begin
            env_phase  = PH_SUSTAIN;
            ramp_count = 0;
            env_level  = sus;
          end
        end
        PH_SUSTAIN: ;
        PH_RELEASE: begin
          env_level = (env_level * (Q16_ONE - shadow_cfg.release_coef)) >> 16;
          if (env_level <= SNAP_MARGIN) begin
            env_level = 0;
            env_phase = PH_IDLE;
          end
        end
        default: begin
          env_phase = PH_IDLE;
          advance   = 1'b0;
        end
      endcase
      if (advance)
        lvl = env_level;
    end

    // counter saturates; it holds in idle and in linear sustain
    if (advance && ramp_count < COUNT_TOP)
      ramp_count++;

    res.envelope_level = lvl[LEVEL_W-1:0];
    res.phase_now      = env_phase;
    phase_seen[env_phase]++;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared state between stimulus, driver, sink and scoreboard.
  // ---------------------------------------------------------------------------
  logic        gate_backlog [$];     // gate samples waiting to be offered
  out_item_t   envelope_forecast [$]; // predicted results, oldest first
  int unsigned gates_queued;
  int unsigned results_checked;
  int unsigned mismatches;
  int unsigned settings_used;
  int unsigned src_gap_max;
  int unsigned snk_stall_max;
  int unsigned hold_req;              // long output hold-off request
  logic        sample_taken;          // input transfer at the last rising edge
  logic        envelope_taken;        // output transfer at the last rising edge

  // Driver: offers queued gate samples, random gap after each transfer.
  int unsigned gap_left = 0;
  always @(negedge clk) begin
    logic     offer;
    in_item_t nxt;
    offer = samples.valid;
    nxt   = samples.data;
    if (!rst) begin
      if (offer && sample_taken)
        offer = 1'b0;
      if (!offer) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (gate_backlog.size() != 0) begin
          nxt.gate_level = gate_backlog.pop_front();
          offer          = 1'b1;
          gap_left       = $urandom_range(0, src_gap_max);
        end
      end
    end
    samples.valid <= offer;
    samples.data  <= nxt;
  end

  // Sink: random stall after each transfer, plus one long hold-off on request
  // so the block backs up and stalls its input.
  int unsigned stall_left = 0;
  int unsigned hold_left  = 0;
  always @(negedge clk) begin
    logic take;
    take = 1'b0;
    if (!rst) begin
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (envelope_taken)
        stall_left = $urandom_range(0, snk_stall_max);
      if (hold_left != 0)
        hold_left--;
      else if (stall_left != 0)
        stall_left--;
      else
        take = 1'b1;
    end
    envelope.ready <= take;
  end

  // Scoreboard: check the output transfer first, then predict the input one,
  // both in one process so queue order never depends on scheduling.
  always @(posedge clk) begin
    out_item_t want;
    sample_taken   <= !rst && samples.valid && samples.ready;
    envelope_taken <= !rst && envelope.valid && envelope.ready;
    if (!rst && envelope.valid && envelope.ready) begin
      if (envelope_forecast.size() == 0) begin
        $error("envelope transfer with no gate sample outstanding");
        mismatches++;
      end else begin
        want = envelope_forecast.pop_front();
        if (envelope.data.envelope_level !== want.envelope_level) begin
          $error("envelope_level: expected %0d, got %0d",
                 want.envelope_level, envelope.data.envelope_level);
          mismatches++;
        end
        if (envelope.data.phase_now !== want.phase_now) begin
          $error("phase_now: expected %0d, got %0d",
                 want.phase_now, envelope.data.phase_now);
          mismatches++;
        end
        results_checked++;
      end
    end
    if (!rst && samples.valid && samples.ready)
      envelope_forecast.push_back(envelope_step(samples.data.gate_level));
  end

  // Watchdog on cycles with no transfer on either side.
  int unsigned stuck_cycles = 0;
  always @(posedge clk) begin
    if (rst || (samples.valid && samples.ready) || (envelope.valid && envelope.ready))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STUCK_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    apply_reg(idx, val);
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  task automatic push_gates(logic g, int unsigned n);
    repeat (n) begin
      gate_backlog.push_back(g);
      gates_queued++;
    end
  endtask

  // Registers only change once every result is back and the block is quiet.
  task automatic wait_drained();
    do @(negedge clk); while (results_checked != gates_queued);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Mostly note-on / note-off pairs with random lengths; some gate noise.
  task automatic queue_notes(int unsigned target);
    int unsigned added;
    int unsigned n;
    added = 0;
    while (added < target) begin
      if ($urandom_range(0, 6) == 0) begin
        n = $urandom_range(1, 8);
        repeat (n) push_gates(1'($urandom_range(0, 1)), 1);
        added += n;
      end else begin
        n = $urandom_range(1, 28);
        push_gates(1'b1, n);
        added += n;
        n = $urandom_range(1, 16);
        push_gates(1'b0, n);
        added += n;
      end
    end
  endtask

  // Short lengths let a note run through every phase; extremes now and then.
  function automatic logic [CFG_DATA_W-1:0] pick_len();
    case ($urandom_range(0, 7))
      0:       return 24'd1;
      1:       return 24'hFFFFFF;
      2:       return 24'($urandom_range(1, 24'hFFFFFF));
      default: return 24'($urandom_range(1, 12));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_coef();
    case ($urandom_range(0, 7))
      0:       return 24'd0;
      1:       return 24'hFFFF;
      2:       return 24'($urandom_range(0, 65535));
      default: return 24'($urandom_range(4096, 65535));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_sustain();
    case ($urandom_range(0, 5))
      0:       return 24'd0;
      1:       return 24'd65536;
      2:       return 24'($urandom_range(65537, 131071));
      default: return 24'($urandom_range(0, 65536));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst             = 1'b1;
    cfg_wr_en       = 1'b0;
    cfg_index       = '0;
    cfg_wdata       = '0;
    samples.valid   = 1'b0;
    samples.data    = '0;
    envelope.ready  = 1'b0;
    sample_taken    = 1'b0;
    envelope_taken  = 1'b0;
    gates_queued    = 0;
    results_checked = 0;
    mismatches      = 0;
    settings_used   = 0;
    src_gap_max     = 16;
    snk_stall_max   = 16;
    hold_req        = 0;
    foreach (phase_seen[i]) phase_seen[i] = 0;

    shadow_cfg = '{curve_mode:     CURVE_MODE_RST,
                   sustain_level:  SUSTAIN_LEVEL_RST,
                   attack_length:  ATTACK_LENGTH_RST,
                   decay_length:   DECAY_LENGTH_RST,
                   release_length: RELEASE_LENGTH_RST,
                   attack_coef:    ATTACK_COEF_RST,
                   decay_coef:     DECAY_COEF_RST,
                   release_coef:   RELEASE_COEF_RST};
    env_phase  = PH_IDLE;
    ramp_count = 0;
    env_level  = 0;
    gate_prev  = 1'b0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed, linear: short attack, zero-length decay, sustain above full
    // scale (clamped), short release run to idle and past it.
    set_reg(REG_CURVE_MODE, 24'd0);
    set_reg(REG_SUSTAIN_LEVEL, 24'd131071);
    set_reg(REG_ATTACK_LENGTH, 24'd2);
    set_reg(REG_DECAY_LENGTH, 24'd0);
    set_reg(REG_RELEASE_LENGTH, 24'd3);
    end_writes();
    push_gates(1'b0, 1);
    push_gates(1'b1, 5);
    push_gates(1'b0, 5);
    wait_drained();

    // Directed, exponential: full-scale coefficients, sustain at zero; one
    // full note, then a one-sample note released in decay, just after its attack.
    set_reg(REG_CURVE_MODE, 24'd1);
    set_reg(REG_SUSTAIN_LEVEL, 24'd0);
    set_reg(REG_ATTACK_COEF, 24'hFFFF);
    set_reg(REG_DECAY_COEF, 24'hFFFF);
    set_reg(REG_RELEASE_COEF, 24'hFFFF);
    end_writes();
    push_gates(1'b1, 4);
    push_gates(1'b0, 3);
    push_gates(1'b1, 1);
    push_gates(1'b0, 2);
    wait_drained();

    // Random phases. State carries across settings on purpose, so mode
    // switches land in whatever phase the last note left behind.
    for (int p = 0; p < 8; p++) begin
      set_reg(REG_CURVE_MODE, 24'(p % 2));
      set_reg(REG_SUSTAIN_LEVEL, pick_sustain());
      if (p == 2) begin
        // longest linear ramps: attack never completes
        set_reg(REG_ATTACK_LENGTH, 24'hFFFFFF);
        set_reg(REG_DECAY_LENGTH, 24'hFFFFFF);
        set_reg(REG_RELEASE_LENGTH, 24'hFFFFFF);
      end else begin
        set_reg(REG_ATTACK_LENGTH, pick_len());
        set_reg(REG_DECAY_LENGTH, pick_len());
        set_reg(REG_RELEASE_LENGTH, pick_len());
      end
      if (p == 5) begin
        // frozen decay and release
        set_reg(REG_ATTACK_COEF, 24'hFFFF);
        set_reg(REG_DECAY_COEF, 24'd0);
        set_reg(REG_RELEASE_COEF, 24'd0);
      end else begin
        set_reg(REG_ATTACK_COEF, pick_coef());
        set_reg(REG_DECAY_COEF, pick_coef());
        set_reg(REG_RELEASE_COEF, pick_coef());
      end
      end_writes();
      // some phases run back to back with no idling on one side
      src_gap_max   = (p % 3 == 2) ? 0 : 16;
      snk_stall_max = (p % 4 == 3) ? 0 : 16;
      if (p == 4)
        hold_req = HOLD_OFF;
      queue_notes(80);
      wait_drained();
    end

    $display("covered %0d gate samples over %0d register settings, both curve modes",
             gates_queued, settings_used);
    $display("phases seen: idle %0d attack %0d decay %0d sustain %0d release %0d",
             phase_seen[PH_IDLE], phase_seen[PH_ATTACK], phase_seen[PH_DECAY],
             phase_seen[PH_SUSTAIN], phase_seen[PH_RELEASE]);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/adsr_pkg.sv
rtl/adsr_stream_if.sv
rtl/adsr_cfg_regs.sv
rtl/adsr_mul.sv
rtl/adsr_div.sv
rtl/adsr_envelope_generator.sv
dv/testbench.sv
